FILE: sv/idr_pkg.sv
// ----------------------------------------------------------------------------
// idr_pkg
// Shared types and constants of the integer divide/remainder core.
// ----------------------------------------------------------------------------
package idr_pkg;

    localparam int LIMB_BITS     = 16;
    localparam int LIMB_COUNT_DEF = 4;
    localparam int OPERAND_W     = 64;
    localparam int OP_W          = 2;

    localparam logic [OP_W-1:0] OP_UQUO = 2'd0;
    localparam logic [OP_W-1:0] OP_UREM = 2'd1;
    localparam logic [OP_W-1:0] OP_SQUO = 2'd2;
    localparam logic [OP_W-1:0] OP_SREM = 2'd3;

    typedef struct packed {
        logic start;
    } idr_div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } idr_div_stat_t;

endpackage

FILE: sv/idr_if.sv
// ----------------------------------------------------------------------------
// idr_req_if / idr_rsp_if
// Valid/ready channels of the divide core: operation request and result.
// ----------------------------------------------------------------------------
interface idr_req_if
    import idr_pkg::*;
    ();
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      operation;
    logic [OPERAND_W-1:0] dividend;
    logic [OPERAND_W-1:0] divisor;

    modport source (output valid, output operation, output dividend, output divisor,
                    input ready);
    modport sink   (input valid, input operation, input dividend, input divisor,
                    output ready);
endinterface

interface idr_rsp_if
    import idr_pkg::*;
    ();
    logic                 valid;
    logic                 ready;
    logic [OPERAND_W-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

FILE: sv/idr_divider.sv
// ----------------------------------------------------------------------------
// idr_divider
// Restoring unsigned divider: one shared subtract/compare per cycle,
// one quotient bit per cycle, DATA_BITS quotient bits per division.
// ----------------------------------------------------------------------------
module idr_divider
    import idr_pkg::*;
#(
    parameter int DATA_BITS = LIMB_BITS * LIMB_COUNT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  idr_div_ctrl_t        ctrl,
    output idr_div_stat_t        stat,
    input  logic [DATA_BITS-1:0] num,
    input  logic [DATA_BITS-1:0] den,
    output logic [DATA_BITS-1:0] quo,
    output logic [DATA_BITS-1:0] rem
);

    localparam int CNT_W = $clog2(DATA_BITS);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DATA_BITS-1:0] rem_reg;
    logic [DATA_BITS-1:0] quo_reg;
    logic [DATA_BITS-1:0] den_reg;

    logic [DATA_BITS:0]   shifted;
    logic [DATA_BITS+1:0] diff;
    logic                 fits;
    logic [DATA_BITS-1:0] rem_next;
    logic [DATA_BITS-1:0] quo_next;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DATA_BITS-1]};
        diff     = {1'b0, shifted} - {2'b00, den_reg};
        fits     = !diff[DATA_BITS+1];
        rem_next = fits ? diff[DATA_BITS-1:0] : shifted[DATA_BITS-1:0];
        quo_next = {quo_reg[DATA_BITS-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DATA_BITS - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;
    assign rem       = rem_reg;

endmodule

FILE: sv/int64_divide_remainder_core.sv
// ----------------------------------------------------------------------------
// int64_divide_remainder_core
// Integer divide unit: unsigned/signed quotient or remainder of two operands.
//
// Channels: req carries operation, dividend and divisor; rsp carries result.
// A transfer happens on a rising clk edge with valid and ready both high.
// Operation: 0 unsigned quotient, 1 unsigned remainder, 2 signed quotient,
// 3 signed remainder. Operands are 16*LIMB_COUNT bits wide (64 by default);
// upper input bits are ignored and upper result bits are zero.
// A zero divisor gives a zero result. Most negative by minus one wraps.
// Quotient bits come from the restoring divider, which produces one quotient
// bit per cycle through a single shared subtractor. One request is in flight
// at a time; req.ready is high only while the unit is idle, so the unit does
// not take a new request before it has posted the result of the last one.
// The result sits in an output register; a stalled receiver holds it, and the
// unit accepts and divides the next request meanwhile, waiting only to post.
// Reset (rst_n low, asynchronous) empties the unit and drops rsp.valid.
// ----------------------------------------------------------------------------
module int64_divide_remainder_core
    import idr_pkg::*;
#(
    parameter int LIMB_COUNT = LIMB_COUNT_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    idr_req_if.sink   req,
    idr_rsp_if.source rsp
);

    localparam int DATA_BITS = LIMB_BITS * LIMB_COUNT;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_OUT
    } state_t;

    state_t               state_reg;
    logic [OP_W-1:0]      op_reg;
    logic                 neg_a_reg;
    logic                 neg_b_reg;
    logic                 zero_reg;
    logic                 rsp_valid_reg;
    logic [DATA_BITS-1:0] result_reg;

    idr_div_ctrl_t        ctrl;
    idr_div_stat_t        stat;
    logic                 accept;
    logic                 is_signed;
    logic [DATA_BITS-1:0] a_raw;
    logic [DATA_BITS-1:0] b_raw;
    logic                 neg_a;
    logic                 neg_b;
    logic [DATA_BITS-1:0] a_mag;
    logic [DATA_BITS-1:0] b_mag;
    logic [DATA_BITS-1:0] quo;
    logic [DATA_BITS-1:0] rem;
    logic [DATA_BITS-1:0] sel;
    logic                 sel_neg;
    logic [DATA_BITS-1:0] result_next;
    logic                 post;

    assign req.ready  = (state_reg == S_IDLE);
    assign accept     = req.valid && req.ready;
    assign ctrl.start = accept;

    always_comb
    begin
        is_signed = req.operation inside {OP_SQUO, OP_SREM};
        a_raw     = req.dividend[DATA_BITS-1:0];
        b_raw     = req.divisor[DATA_BITS-1:0];
        neg_a     = is_signed && a_raw[DATA_BITS-1];
        neg_b     = is_signed && b_raw[DATA_BITS-1];
        a_mag     = neg_a ? ('0 - a_raw) : a_raw;
        b_mag     = neg_b ? ('0 - b_raw) : b_raw;
    end

    idr_divider #(
        .DATA_BITS (DATA_BITS)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .stat  (stat),
        .num   (a_mag),
        .den   (b_mag),
        .quo   (quo),
        .rem   (rem)
    );

    always_comb
    begin
        case (op_reg)
            OP_UQUO:
            begin
                sel     = quo;
                sel_neg = 1'b0;
            end
            OP_UREM:
            begin
                sel     = rem;
                sel_neg = 1'b0;
            end
            OP_SQUO:
            begin
                sel     = quo;
                sel_neg = neg_a_reg ^ neg_b_reg;
            end
            default:
            begin
                sel     = rem;
                sel_neg = neg_a_reg;
            end
        endcase
        if (zero_reg)
            result_next = '0;
        else
            result_next = sel_neg ? ('0 - sel) : sel;
    end

    assign post = !rsp_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            op_reg        <= OP_UQUO;
            neg_a_reg     <= 1'b0;
            neg_b_reg     <= 1'b0;
            zero_reg      <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready && state_reg != S_OUT)
                rsp_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_DIV;
                        op_reg    <= req.operation;
                        neg_a_reg <= neg_a;
                        neg_b_reg <= neg_b;
                        zero_reg  <= (b_raw == '0);
                    end
                end
                S_DIV:
                begin
                    if (stat.done)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (post)
                    begin
                        result_reg    <= result_next;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.result = OPERAND_W'(result_reg);

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        stat.busy |-> !req.ready)
        else $error("request taken while divider busy");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> stat.busy)
        else $error("divider not started after request transfer");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> (state_reg == S_DIV))
        else $error("divider finished outside divide state");

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for int64_divide_remainder_core (64-bit operands).
// A short table of directed transfers covers the operand extremes, every
// operation, a zero divisor and the most negative value divided by minus one.
// About 500 random transfers follow, with operands drawn from full-width,
// narrowed, small, negative and corner classes. Every result is compared in
// order against its table value or a bit-serial restoring divider in the
// bench. Both channels idle at random, and the result side holds off once
// for a long stretch so that the request side backs up.
// ----------------------------------------------------------------------------
module tb_top;
    import idr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MOST_NEG  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MOST_POS  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int          N_DIRECTED = 20;
    localparam int          N_RANDOM   = 500;
    localparam int          HOLD_CYCLES = 400;
    localparam int          HOLD_AFTER  = 40;
    localparam int          DRAIN_CYCLES = 80;

    typedef struct packed {
        logic              known;
        logic [OP_W-1:0]   operation;
        logic [63:0]       dividend;
        logic [63:0]       divisor;
        logic [63:0]       result;
    } div_case_t;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [63:0]       dividend;
        logic [63:0]       divisor;
        logic [63:0]       result;
    } div_expect_t;

    logic        clk = 1'b0;
    logic        rst_n;
    div_expect_t pending_results[$];
    int          mismatches = 0;
    int          results_seen = 0;
    div_case_t   directed_rows[N_DIRECTED];

    idr_req_if req_ch ();
    idr_rsp_if rsp_ch ();

    int64_divide_remainder_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #1 clk = ~clk;

    function automatic logic [63:0] predict_divide(input logic [OP_W-1:0] operation,
                                                   input logic [63:0] dividend,
                                                   input logic [63:0] divisor);
        logic        is_signed;
        logic        neg_n;
        logic        neg_d;
        logic [63:0] mag_n;
        logic [63:0] mag_d;
        logic [63:0] quo;
        logic [63:0] rem;
        logic [64:0] partial;
        is_signed = (operation == OP_SQUO) || (operation == OP_SREM);
        neg_n = is_signed && dividend[63];
        neg_d = is_signed && divisor[63];
        mag_n = neg_n ? (64'd0 - dividend) : dividend;
        mag_d = neg_d ? (64'd0 - divisor) : divisor;
        quo = '0;
        rem = '0;
        if (mag_d != '0)
        begin
            for (int bit_idx = 63; bit_idx >= 0; bit_idx--)
            begin
                partial = {rem, mag_n[bit_idx]};
                quo = quo << 1;
                if (partial >= {1'b0, mag_d})
                begin
                    partial = partial - {1'b0, mag_d};
                    quo[0] = 1'b1;
                end
                rem = partial[63:0];
            end
        end
        case (operation)
            OP_UQUO: return quo;
            OP_UREM: return rem;
            OP_SQUO: return (neg_n != neg_d) ? (64'd0 - quo) : quo;
            default: return neg_n ? (64'd0 - rem) : rem;
        endcase
    endfunction

    function automatic logic [63:0] pick_operand();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            3: v = v >> $urandom_range(0, 63);
            4: v = 64'($urandom_range(0, 16));
            5: v = 64'd0 - 64'($urandom_range(1, 16));
            6:
            begin
                case ($urandom_range(0, 4))
                    0: v = '0;
                    1: v = 64'd1;
                    2: v = MOST_NEG;
                    3: v = MOST_POS;
                    default: v = ALL_ONES;
                endcase
            end
            7: v = 64'd0 - (v >> $urandom_range(1, 63));
            default: ;
        endcase
        return v;
    endfunction

    function automatic int draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 10);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t tb_top: mismatch: %s", $realtime, msg);
    endtask

    // one request transfer; valid stays high into the next item when gap is 0
    task automatic send_item(input logic [OP_W-1:0] operation, input logic [63:0] dividend,
                             input logic [63:0] divisor, input logic known,
                             input logic [63:0] result, input int gap);
        div_expect_t entry;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= operation;
        req_ch.dividend  <= dividend;
        req_ch.divisor   <= divisor;
        do @(negedge clk); while (!req_ch.ready);
        entry.operation = operation;
        entry.dividend  = dividend;
        entry.divisor   = divisor;
        entry.result    = known ? result : predict_divide(operation, dividend, divisor);
        pending_results.push_back(entry);
        @(posedge clk);
    endtask

    initial
    begin
        directed_rows = '{
            '{1'b1, OP_UQUO, ALL_ONES, 64'd1,    ALL_ONES},
            '{1'b1, OP_UREM, ALL_ONES, 64'd1,    64'd0},
            '{1'b1, OP_SQUO, MOST_NEG, ALL_ONES, MOST_NEG},
            '{1'b1, OP_SREM, MOST_NEG, ALL_ONES, 64'd0},
            '{1'b1, OP_UQUO, 64'd123,  64'd0,    64'd0},
            '{1'b1, OP_UREM, ALL_ONES, 64'd0,    64'd0},
            '{1'b1, OP_SQUO, MOST_NEG, 64'd0,    64'd0},
            '{1'b1, OP_SREM, MOST_POS, 64'd0,    64'd0},
            '{1'b1, OP_UQUO, ALL_ONES, ALL_ONES, 64'd1},
            '{1'b1, OP_UREM, 64'd0,    ALL_ONES, 64'd0},
            '{1'b1, OP_UQUO, 64'd0,    64'd0,    64'd0},
            '{1'b1, OP_SQUO, MOST_NEG, 64'd1,    MOST_NEG},
            '{1'b0, OP_SQUO, 64'd0 - 64'd7, 64'd2,         64'd0},
            '{1'b0, OP_SREM, 64'd0 - 64'd7, 64'd2,         64'd0},
            '{1'b0, OP_SQUO, 64'd7,         64'd0 - 64'd2, 64'd0},
            '{1'b0, OP_SREM, 64'd7,         64'd0 - 64'd2, 64'd0},
            '{1'b0, OP_UQUO, MOST_NEG,      64'd3,         64'd0},
            '{1'b0, OP_SREM, MOST_POS,      MOST_NEG,      64'd0},
            '{1'b0, OP_UREM, 64'd5,         MOST_NEG,      64'd0},
            '{1'b0, OP_SQUO, MOST_POS,      ALL_ONES,      64'd0}
        };
    end

    // result side: random stalls, one long hold-off after HOLD_AFTER results
    initial
    begin
        int  gap;
        bit  calm;
        bit  held;
        int  hold_count;
        div_expect_t want;
        calm = 1'b0;
        held = 1'b0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (results_seen % 40 == 0)
                calm = ($urandom_range(0, 2) == 0);
            gap = draw_gap(calm);
            if (!held && results_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                gap = HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_count = 0;
                while (hold_count < gap)
                begin
                    @(posedge clk);
                    hold_count++;
                end
            end
            rsp_ch.ready <= 1'b1;
            do @(negedge clk); while (!rsp_ch.valid);
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result %h", rsp_ch.result));
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.result !== want.result)
                    report_mismatch($sformatf("op %0d %h / %h: result %h, expected %h",
                                              want.operation, want.dividend, want.divisor,
                                              rsp_ch.result, want.result));
            end
            @(posedge clk);
        end
    end

    initial
    begin
        int  gap;
        bit  calm;
        int  drain;
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.operation <= OP_UQUO;
        req_ch.dividend  <= '0;
        req_ch.divisor   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        calm = 1'b0;
        for (int row = 0; row < N_DIRECTED; row++)
        begin
            gap = draw_gap(calm);
            send_item(directed_rows[row].operation, directed_rows[row].dividend,
                      directed_rows[row].divisor, directed_rows[row].known,
                      directed_rows[row].result, gap);
        end

        for (int item = 0; item < N_RANDOM; item++)
        begin
            if (item % 40 == 0)
                calm = ($urandom_range(0, 2) == 0);
            gap = draw_gap(calm);
            send_item(OP_W'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                      1'b0, '0, gap);
        end
        req_ch.valid <= 1'b0;

        drain = 0;
        while (pending_results.size() != 0 && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        #500_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

FILE: sim.f
sv/idr_pkg.sv
sv/idr_if.sv
sv/idr_divider.sv
sv/int64_divide_remainder_core.sv
tb/tb_top.sv
